// ----- hdl/dshot4_pkg.sv -----
// ----------------------------------------------------------------------------
// DShot four-channel framer package
// Shared widths, reset values, register indexes and word types.
// ----------------------------------------------------------------------------
`default_nettype none

package dshot4_pkg;

  localparam int MotorCount       = 4;
  localparam int ValueWidth       = 11;
  localparam int InValueWidth     = 16;
  localparam int FrameBits        = 16;
  localparam int BitIdxWidth      = $clog2(FrameBits);
  localparam int HoldSlotsDefault = 3;
  localparam int CfgIdxWidth      = 1;

  localparam logic [ValueWidth-1:0] MinThrottleReset = 11'd48;
  localparam logic [ValueWidth-1:0] MaxValueReset    = 11'd2047;

  localparam logic [CfgIdxWidth-1:0] CfgMinThrottle = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgMaxValue    = 1'b1;

  typedef logic [FrameBits-1:0] frame_t;

  typedef struct packed {
    logic [InValueWidth-1:0] motor1_value;
    logic [InValueWidth-1:0] motor2_value;
    logic [InValueWidth-1:0] motor3_value;
    logic [InValueWidth-1:0] motor4_value;
    logic                    telemetry_request;
  } in_word_t;

  typedef struct packed {
    logic [MotorCount-1:0] pin_levels;
    logic                  status;
    logic                  last_slot;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic reject;
  } pend_t;

endpackage

`default_nettype wire

// ----- hdl/dshot_four_channel_framer_top.sv -----
// ----------------------------------------------------------------------------
// DShot four-channel framer
// Range-checks four throttle values and serialises their DShot frames.
// ----------------------------------------------------------------------------
// An accepted word is range-checked and framed by four parallel lanes, which
// register it on acceptance; the serialiser then plays it out at one slot per
// cycle while out_stall_i is low: 48 bit slots plus HOLD_SLOTS hold slots (51
// with the default), or a single rejected word. The serialiser's slot counter
// sets the rate; one further word is buffered in the lanes while the current
// one plays out, so a new word is taken as the last slot is accepted.
// Acceptance sets the pending flag; take_o then starts the first slot.
`default_nettype none

module dshot_four_channel_framer_top #(
  parameter int HOLD_SLOTS = dshot4_pkg::HoldSlotsDefault
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  dshot4_pkg::in_word_t                in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output dshot4_pkg::out_word_t               out_data_o,
  input  wire                                 cfg_we_i,
  input  wire  [dshot4_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire  [dshot4_pkg::ValueWidth-1:0]   cfg_wdata_i
);
  import dshot4_pkg::*;

  logic [ValueWidth-1:0]   min_throttle_q;
  logic [ValueWidth-1:0]   max_value_q;
  logic                    pend_valid_q;
  logic                    pend_valid_d;
  logic                    in_take;
  logic                    take;
  logic [InValueWidth-1:0] values [MotorCount];
  frame_t                  frames [MotorCount];
  logic [MotorCount-1:0]   lane_ok;
  pend_t                   pend;

  assign values[0] = in_data_i.motor1_value;
  assign values[1] = in_data_i.motor2_value;
  assign values[2] = in_data_i.motor3_value;
  assign values[3] = in_data_i.motor4_value;

  assign in_stall_o   = pend_valid_q;
  assign in_take      = in_valid_i && !in_stall_o;
  assign pend_valid_d = in_take || (pend_valid_q && !take);
  assign pend.valid   = pend_valid_q;
  assign pend.reject  = !(&lane_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q   <= 1'b0;
      min_throttle_q <= MinThrottleReset;
      max_value_q    <= MaxValueReset;
    end else begin
      pend_valid_q <= pend_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgMinThrottle: min_throttle_q <= cfg_wdata_i;
          CfgMaxValue:    max_value_q    <= cfg_wdata_i;
          default:        ;
        endcase
      end
    end
  end

  for (genvar m = 0; m < MotorCount; m++) begin : g_lane
    dshot4_lane u_lane (
      .clk_i          (clk_i),
      .load_i         (in_take),
      .value_i        (values[m]),
      .telem_i        (in_data_i.telemetry_request),
      .min_throttle_i (min_throttle_q),
      .max_value_i    (max_value_q),
      .ok_o           (lane_ok[m]),
      .frame_o        (frames[m])
    );
  end

  dshot4_serializer #(
    .HOLD_SLOTS (HOLD_SLOTS)
  ) u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pend_i      (pend),
    .frames_i    (frames),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- hdl/dshot4_lane.sv -----
// ----------------------------------------------------------------------------
// DShot lane
// Range-checks one motor value and holds its 16-bit frame until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dshot4_lane (
  input  wire                                   clk_i,
  input  wire                                   load_i,
  input  wire  [dshot4_pkg::InValueWidth-1:0]   value_i,
  input  wire                                   telem_i,
  input  wire  [dshot4_pkg::ValueWidth-1:0]     min_throttle_i,
  input  wire  [dshot4_pkg::ValueWidth-1:0]     max_value_i,
  output logic                                  ok_o,
  output dshot4_pkg::frame_t                    frame_o
);
  import dshot4_pkg::*;

  logic                  ok_d;
  logic                  ok_q;
  frame_t                frame_d;
  frame_t                frame_q;
  logic [ValueWidth:0]   payload;
  logic [3:0]            csum;

  always_comb begin
    ok_d = !((value_i > InValueWidth'(max_value_i)) ||
             ((value_i != '0) && (value_i < InValueWidth'(min_throttle_i))));
    payload = {value_i[ValueWidth-1:0], telem_i};
    csum    = payload[3:0] ^ payload[7:4] ^ payload[11:8];
    frame_d = {payload, csum};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ok_q    <= ok_d;
      frame_q <= frame_d;
    end
  end

  assign ok_o    = ok_q;
  assign frame_o = frame_q;

endmodule

`default_nettype wire

// ----- hdl/dshot4_serializer.sv -----
// ----------------------------------------------------------------------------
// DShot serializer
// Merges the lane frames and plays out the bit slots and hold slots, or one reject slot.
// ----------------------------------------------------------------------------
`default_nettype none

module dshot4_serializer #(
  parameter int HOLD_SLOTS = dshot4_pkg::HoldSlotsDefault
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  dshot4_pkg::pend_t     pend_i,
  input  dshot4_pkg::frame_t    frames_i [dshot4_pkg::MotorCount],
  output logic                  take_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output dshot4_pkg::out_word_t out_data_o
);
  import dshot4_pkg::*;

  localparam int HoldW = (HOLD_SLOTS > 1) ? $clog2(HOLD_SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REJECT,
    ST_HIGH,
    ST_DATA,
    ST_LOW,
    ST_HOLD
  } state_e;

  state_e                 state_q;
  logic [BitIdxWidth-1:0] bit_q;
  logic [HoldW-1:0]       hold_q;
  frame_t                 frames_q [MotorCount];
  logic                   out_take;
  logic                   is_last;
  logic [BitIdxWidth-1:0] bit_sel;
  logic [MotorCount-1:0]  data_bits;

  always_comb begin
    bit_sel = BitIdxWidth'(FrameBits - 1) - bit_q;
    for (int m = 0; m < MotorCount; m++) begin
      data_bits[m] = frames_q[m][bit_sel];
    end
  end

  assign out_valid_o = (state_q != ST_IDLE);
  assign out_take    = out_valid_o && !out_stall_i;
  assign is_last     = (state_q == ST_REJECT) ||
                       ((state_q == ST_HOLD) && (hold_q == HoldW'(HOLD_SLOTS - 1)));
  assign take_o      = pend_i.valid && ((state_q == ST_IDLE) || (out_take && is_last));

  always_comb begin
    out_data_o.status    = (state_q == ST_REJECT);
    out_data_o.last_slot = is_last;
    unique case (state_q)
      ST_HIGH: out_data_o.pin_levels = '1;
      ST_DATA: out_data_o.pin_levels = data_bits;
      default: out_data_o.pin_levels = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
      hold_q  <= '0;
    end else if (take_o) begin
      state_q <= pend_i.reject ? ST_REJECT : ST_HIGH;
      bit_q   <= '0;
      hold_q  <= '0;
    end else if (out_take) begin
      unique case (state_q)
        ST_HIGH: state_q <= ST_DATA;
        ST_DATA: state_q <= ST_LOW;
        ST_LOW: begin
          if (bit_q == BitIdxWidth'(FrameBits - 1)) begin
            state_q <= ST_HOLD;
            hold_q  <= '0;
          end else begin
            state_q <= ST_HIGH;
            bit_q   <= bit_q + 1'b1;
          end
        end
        ST_HOLD: begin
          if (is_last) begin
            state_q <= ST_IDLE;
          end else begin
            hold_q <= hold_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      frames_q <= frames_i;
    end
  end

  a_reject_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.last_slot)
    else $error("rejected word not marked last");

  a_last_is_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_slot |-> out_data_o.pin_levels == '0)
    else $error("final word drives a pin high");

  a_drain_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && is_last && !pend_i.valid |=> !out_valid_o)
    else $error("words continue after the final slot");

  a_high_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && (state_q == ST_HIGH) |=> out_valid_o && !out_data_o.status &&
                                         !out_data_o.last_slot)
    else $error("high slot not followed by data slot");

endmodule

`default_nettype wire
